FILE: hw/rtl/lfu_pkg.sv
// shared constants and types for the lfu page replacement unit
`default_nettype none
package lfu_pkg;

    localparam int NUM_FRAMES_DEF = 8;
    localparam int PAGE_W         = 16;
    localparam int CNT_W          = 16;
    localparam int TIME_W         = 32;
    localparam int FAULT_W        = 32;
    localparam int CFG_W          = 4;
    localparam int IDX_OUT_W      = 3;
    localparam int IN_DATA_W      = 16;
    localparam int OUT_FIELDS_W   = 1 + IDX_OUT_W + 1 + PAGE_W + FAULT_W;
    localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // output tdata bit positions
    localparam int O_HIT    = 0;
    localparam int O_IDX_LO = 1;
    localparam int O_EV     = O_IDX_LO + IDX_OUT_W;
    localparam int O_EVP_LO = O_EV + 1;
    localparam int O_FLT_LO = O_EVP_LO + PAGE_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_UPD  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0] last;
    } t_entry;

endpackage
`default_nettype wire

FILE: hw/rtl/lfu_page_replacement_unit.sv
// lfu page replacement unit: frame table, scan sequencer and result register
//
// One page reference is taken at a time. The frame table has a single read
// port, so the scan reads one entry of the n active frames (frames_in_use
// clamped to 1..NUM_FRAMES) per cycle into one shared compare stage that
// tracks the hit, the first empty frame and the least-used victim; then the
// update state writes the chosen frame and loads the result register.
// A settle state follows the update and the input is ready again in the
// cycle after it, so a new reference is accepted only after the last one is
// written; if the previous result is still held, the update waits for it to
// be taken.
`default_nettype none
module lfu_page_replacement_unit #(
    parameter int NUM_FRAMES = lfu_pkg::NUM_FRAMES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [lfu_pkg::CFG_W-1:0]      i_cfg_wr_data,  // frames_in_use
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    input  wire logic [lfu_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // page
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // hit, frame_index, evicted_valid, evicted_page, fault_count, zero pad
    output      logic [lfu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam logic [IW-1:0] LAST_MAX = IW'(NUM_FRAMES - 1);

    lfu_pkg::t_state r_state, n_state;

    logic [lfu_pkg::CFG_W-1:0]   r_fiu;
    logic [NUM_FRAMES-1:0]       r_occ;
    lfu_pkg::t_entry             r_mem [NUM_FRAMES];
    lfu_pkg::t_entry             r_rd_data;
    logic [lfu_pkg::TIME_W-1:0]  r_time;
    logic [lfu_pkg::FAULT_W-1:0] r_fault;

    logic [lfu_pkg::PAGE_W-1:0]  r_page;
    logic [IW-1:0]               r_last;
    logic [IW-1:0]               r_addr;
    logic                        r_issue_on;
    logic                        r_rd_vld;
    logic [IW-1:0]               r_rd_idx;

    logic                        r_found;
    logic [IW-1:0]               r_hit_idx;
    logic [lfu_pkg::CNT_W-1:0]   r_hit_cnt;
    logic                        r_empty_found;
    logic [IW-1:0]               r_empty_idx;
    logic [IW-1:0]               r_best_idx;
    logic [lfu_pkg::CNT_W-1:0]   r_best_cnt;
    logic [lfu_pkg::TIME_W-1:0]  r_best_time;
    logic [lfu_pkg::PAGE_W-1:0]  r_best_page;

    logic                           r_out_valid;
    logic [lfu_pkg::OUT_FIELDS_W-1:0] r_out_data;

    logic                        w_accept;
    logic                        w_upd_go;
    logic                        w_scan_done;
    logic [IW-1:0]               w_last;
    logic                        w_occ;
    logic                        w_match;
    logic                        w_better;
    logic [IW-1:0]               w_slot;
    logic                        w_ev;
    logic [lfu_pkg::CNT_W-1:0]   w_new_cnt;
    logic [lfu_pkg::FAULT_W-1:0] w_new_fault;
    lfu_pkg::t_entry             w_wr_entry;

    assign s_axis_tready = (r_state == lfu_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_scan_done   = r_rd_vld && (r_rd_idx == r_last);
    assign w_upd_go      = (r_state == lfu_pkg::S_UPD) && (!r_out_valid || m_axis_tready);

    // clamp the active frame count to 1..NUM_FRAMES, kept as last index
    always_comb begin
        if (r_fiu == '0) begin
            w_last = '0;
        end else if (32'(r_fiu) > NUM_FRAMES) begin
            w_last = LAST_MAX;
        end else begin
            w_last = IW'(32'(r_fiu) - 32'd1);
        end
    end

    assign w_occ    = r_occ[r_rd_idx];
    assign w_match  = w_occ && (r_rd_data.page == r_page);
    assign w_better = (r_rd_data.cnt < r_best_cnt) ||
                      ((r_rd_data.cnt == r_best_cnt) && (r_rd_data.last > r_best_time));

    always_comb begin
        if (r_found) begin
            w_slot = r_hit_idx;
        end else if (r_empty_found) begin
            w_slot = r_empty_idx;
        end else begin
            w_slot = r_best_idx;
        end
    end

    assign w_ev        = !r_found && !r_empty_found;
    assign w_new_cnt   = r_found ? ((r_hit_cnt == lfu_pkg::CNT_MAX) ? r_hit_cnt
                                                                    : r_hit_cnt + 1'b1)
                                 : lfu_pkg::CNT_W'(1);
    assign w_new_fault = (r_found || r_fault == lfu_pkg::FAULT_MAX) ? r_fault
                                                                   : r_fault + 1'b1;
    assign w_wr_entry  = '{page: r_page, cnt: w_new_cnt, last: r_time};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfu_pkg::S_IDLE: begin
                if (w_accept) n_state = lfu_pkg::S_SCAN;
            end
            lfu_pkg::S_SCAN: begin
                if (w_scan_done) n_state = lfu_pkg::S_UPD;
            end
            lfu_pkg::S_UPD: begin
                if (w_upd_go) n_state = lfu_pkg::S_WAIT;
            end
            lfu_pkg::S_WAIT: begin
                n_state = lfu_pkg::S_IDLE;
            end
            default: n_state = lfu_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfu_pkg::S_IDLE;
            r_fiu       <= lfu_pkg::CFG_RESET;
            r_occ       <= '0;
            r_time      <= '0;
            r_fault     <= '0;
            r_issue_on  <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_fiu <= i_cfg_wr_data;
            r_rd_vld <= (r_state == lfu_pkg::S_SCAN) && r_issue_on;
            if (w_accept) begin
                r_issue_on <= 1'b1;
            end else if (r_issue_on && r_addr == r_last) begin
                r_issue_on <= 1'b0;
            end
            if (w_upd_go) begin
                r_occ[w_slot] <= 1'b1;
                r_fault       <= w_new_fault;
                if (r_time != lfu_pkg::TIME_MAX) r_time <= r_time + 1'b1;
                r_out_valid   <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // frame table
    always_ff @(posedge i_clk) begin
        if (w_upd_go) r_mem[w_slot] <= w_wr_entry;
        r_rd_data <= r_mem[r_addr];
    end

    // scan address, compare stage and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= s_axis_tdata[lfu_pkg::PAGE_W-1:0];
            r_last <= w_last;
            r_addr <= '0;
        end else if (r_issue_on && r_addr != r_last) begin
            r_addr <= r_addr + 1'b1;
        end
        r_rd_idx <= r_addr;
        if (r_rd_vld) begin
            if (r_rd_idx == '0) begin
                r_found       <= w_match;
                r_hit_idx     <= '0;
                r_hit_cnt     <= r_rd_data.cnt;
                r_empty_found <= !w_occ;
                r_empty_idx   <= '0;
                r_best_idx    <= '0;
                r_best_cnt    <= r_rd_data.cnt;
                r_best_time   <= r_rd_data.last;
                r_best_page   <= r_rd_data.page;
            end else begin
                if (!r_found && w_match) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                    r_hit_cnt <= r_rd_data.cnt;
                end
                if (!r_empty_found && !w_occ) begin
                    r_empty_found <= 1'b1;
                    r_empty_idx   <= r_rd_idx;
                end
                if (w_better) begin
                    r_best_idx  <= r_rd_idx;
                    r_best_cnt  <= r_rd_data.cnt;
                    r_best_time <= r_rd_data.last;
                    r_best_page <= r_rd_data.page;
                end
            end
        end
        if (w_upd_go) begin
            r_out_data <= {w_new_fault,
                           w_ev ? r_best_page : lfu_pkg::PAGE_W'(0),
                           w_ev,
                           lfu_pkg::IDX_OUT_W'(w_slot),
                           r_found};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = lfu_pkg::OUT_DATA_W'(r_out_data);

endmodule
`default_nettype wire

FILE: hw/rtl/lfu_chk.sv
// port-level checks for the lfu page replacement unit, bound to the top level
`default_nettype none
module lfu_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [lfu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready during scan");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[lfu_pkg::O_HIT] |-> !m_axis_tdata[lfu_pkg::O_EV])
        else $error("eviction reported on a hit");

    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[lfu_pkg::O_EV] |->
            m_axis_tdata[lfu_pkg::O_FLT_LO-1:lfu_pkg::O_EVP_LO] == '0)
        else $error("evicted page set without eviction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind lfu_page_replacement_unit lfu_chk u_lfu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: sim/lfu_page_replacement_unit_tb.sv
// testbench for the lfu page replacement unit: directed, random and stall tests
`timescale 1ns / 100ps

module lfu_page_replacement_unit_tb;

    localparam int NUM_FRAMES  = lfu_pkg::NUM_FRAMES_DEF;
    localparam int NO_FRAME    = -1;
    localparam int DRAIN_GAP   = NUM_FRAMES + 3;
    localparam int HOLD_LEN    = 300;
    localparam int CYCLE_LIMIT = 2_500_000;

    typedef struct packed {
        logic                          hit;
        logic [lfu_pkg::IDX_OUT_W-1:0] frame_index;
        logic                          evicted_valid;
        logic [lfu_pkg::PAGE_W-1:0]    evicted_page;
        logic [lfu_pkg::FAULT_W-1:0]   fault_count;
    } t_lfu_result;

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_wr_en   = 1'b0;
    logic [lfu_pkg::CFG_W-1:0]      i_cfg_wr_data = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [lfu_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [lfu_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // frame table mirror
    logic                         occ       [NUM_FRAMES];
    logic [lfu_pkg::PAGE_W-1:0]   frame_pg  [NUM_FRAMES];
    logic [lfu_pkg::CNT_W-1:0]    use_cnt   [NUM_FRAMES];
    logic [lfu_pkg::TIME_W-1:0]   last_ref  [NUM_FRAMES];
    logic [lfu_pkg::TIME_W-1:0]   ref_clock = '0;
    logic [lfu_pkg::FAULT_W-1:0]  faults    = '0;
    logic [lfu_pkg::CFG_W-1:0]    frame_limit = lfu_pkg::CFG_RESET;

    t_lfu_result pending_results[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit hold_req       = 1'b0;
    int hold_count     = 0;
    int fail_count     = 0;
    int pages_sent     = 0;
    int results_seen   = 0;
    int hits_seen      = 0;
    int evictions_seen = 0;

    lfu_page_replacement_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            occ[i]      = 1'b0;
            frame_pg[i] = '0;
            use_cnt[i]  = '0;
            last_ref[i] = '0;
        end
    end

    function automatic t_lfu_result lfu_predict(input logic [lfu_pkg::PAGE_W-1:0] page);
        t_lfu_result r;
        int          n;
        int          slot;
        bit          found;
        r     = '0;
        n     = (frame_limit == '0) ? 1 :
                ((int'(frame_limit) > NUM_FRAMES) ? NUM_FRAMES : int'(frame_limit));
        slot  = NO_FRAME;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (!found && occ[i] && frame_pg[i] == page) begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            if (use_cnt[slot] != lfu_pkg::CNT_MAX)
                use_cnt[slot] = use_cnt[slot] + 1'b1;
            last_ref[slot] = ref_clock;
        end else begin
            for (int i = 0; i < n; i++)
                if (slot == NO_FRAME && !occ[i])
                    slot = i;
            if (slot == NO_FRAME) begin
                slot = 0;
                for (int i = 1; i < n; i++) begin
                    if (use_cnt[i] < use_cnt[slot] ||
                        (use_cnt[i] == use_cnt[slot] && last_ref[i] > last_ref[slot]))
                        slot = i;
                end
            end
            if (occ[slot]) begin
                r.evicted_valid = 1'b1;
                r.evicted_page  = frame_pg[slot];
            end
            occ[slot]      = 1'b1;
            frame_pg[slot] = page;
            use_cnt[slot]  = lfu_pkg::CNT_W'(1);
            last_ref[slot] = ref_clock;
            if (faults != lfu_pkg::FAULT_MAX)
                faults = faults + 1'b1;
        end
        if (ref_clock != lfu_pkg::TIME_MAX)
            ref_clock = ref_clock + 1'b1;
        r.hit         = found;
        r.frame_index = slot[lfu_pkg::IDX_OUT_W-1:0];
        r.fault_count = faults;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic check_result(input logic [lfu_pkg::OUT_DATA_W-1:0] d);
        t_lfu_result e;
        if (pending_results.size() == 0) begin
            $error("result transfer with no expected result, tdata 0x%0h", d);
            fail_count++;
        end else begin
            e = pending_results.pop_front();
            compare_field("hit", 32'(e.hit), 32'(d[lfu_pkg::O_HIT]));
            compare_field("frame_index", 32'(e.frame_index),
                          32'(d[lfu_pkg::O_IDX_LO +: lfu_pkg::IDX_OUT_W]));
            compare_field("evicted_valid", 32'(e.evicted_valid), 32'(d[lfu_pkg::O_EV]));
            compare_field("evicted_page", 32'(e.evicted_page),
                          32'(d[lfu_pkg::O_EVP_LO +: lfu_pkg::PAGE_W]));
            compare_field("fault_count", e.fault_count,
                          d[lfu_pkg::O_FLT_LO +: lfu_pkg::FAULT_W]);
        end
        results_seen++;
        if (d[lfu_pkg::O_HIT])
            hits_seen++;
        if (d[lfu_pkg::O_EV])
            evictions_seen++;
    endtask

    always @(posedge i_clk) begin : result_monitor
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result(m_axis_tdata);
        if (hold_req) begin
            hold_count = hold_count + 1;
            if (hold_count >= HOLD_LEN) begin
                hold_count = 0;
                hold_req   = 1'b0;
            end
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_page(input logic [lfu_pkg::PAGE_W-1:0] page);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(lfu_predict(page));
        pages_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_frames_in_use(input logic [lfu_pkg::CFG_W-1:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        frame_limit = value;
    endtask

    task automatic test_reset_fill_evict();
        logic [lfu_pkg::PAGE_W-1:0] fill_pages [8];
        fill_pages = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                       16'h0001, 16'h0002, 16'h0003, 16'h0004};
        foreach (fill_pages[i])
            send_page(fill_pages[i]);
        send_page(16'hFFFF);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h1234);
        send_page(16'h4321);
        wait_idle();
    endtask

    task automatic test_frame_count_limits();
        // zero acts as one frame
        write_frames_in_use(4'd0);
        send_page(16'h0F0F);
        send_page(16'h0F0F);
        send_page(16'hF0F0);
        // above the frame count acts as all frames
        write_frames_in_use(4'd15);
        send_page(16'hFFFF);
        send_page(16'h7777);
        // shrunk count hides the upper frames
        write_frames_in_use(4'd3);
        send_page(16'h0002);
        send_page(16'h0003);
        write_frames_in_use(4'd8);
        send_page(16'h0003);
        send_page(16'h0002);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct, input int count);
        logic [lfu_pkg::PAGE_W-1:0] base;
        int                         ws;
        logic [lfu_pkg::CFG_W-1:0]  cfg;
        wait_idle();
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        base = '0;
        ws   = 1;
        for (int k = 0; k < count; k++) begin
            if (k % 133 == 0) begin
                case (k / 133)
                    0:       cfg = 4'd8;
                    1:       cfg = 4'd1;
                    default: cfg = lfu_pkg::CFG_W'($urandom_range(15));
                endcase
                write_frames_in_use(cfg);
            end
            if (k % 40 == 0) begin
                base = lfu_pkg::PAGE_W'($urandom_range(65535));
                ws   = $urandom_range(1, 12);
            end
            if ($urandom_range(99) < 15)
                send_page(lfu_pkg::PAGE_W'($urandom_range(65535)));
            else
                send_page(base + lfu_pkg::PAGE_W'($urandom_range(ws - 1)));
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_frames_in_use(4'd4);
        hold_req = 1'b1;
        for (int k = 0; k < 8; k++)
            send_page(lfu_pkg::PAGE_W'($urandom_range(7)));
        wait_idle();
    endtask

    task automatic test_repeated_hits();
        logic [lfu_pkg::PAGE_W-1:0] hot;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hot = lfu_pkg::PAGE_W'($urandom_range(65535));
        write_frames_in_use(4'd1);
        for (int k = 0; k < 20; k++)
            send_page(hot);
        // the heavily used frame must survive fresh pages
        write_frames_in_use(4'd2);
        send_page(hot ^ 16'hFFFF);
        send_page(hot ^ 16'h8000);
        send_page(hot);
        wait_idle();
    endtask

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : test_sequence
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_fill_evict();
        test_frame_count_limits();
        test_random_traffic(31, 73, 532);
        test_random_traffic(73, 31, 532);
        test_random_traffic(0, 0, 532);
        test_output_backpressure();
        test_repeated_hits();
        $display("covered %0d page references, %0d results, %0d hits, %0d evictions",
                 pages_sent, results_seen, hits_seen, evictions_seen);
        $display("frame counts 0 to 15, output stall, idle mixes and repeated hits");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
